// ===== hdl/agrc_pkg.sv =====
// Package for the audio gain ramp / crossfade block: widths, register indexes,
// mode and state codes, and the saturation helper.
// No dependencies.
package agrc_pkg;

    localparam int MAX_BLOCK = 4096;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int LEN_W     = 13;
    localparam int POS_W     = $clog2(MAX_BLOCK);
    localparam int WT_W      = 17;              // weight 0..65536, 16 fraction bits
    localparam int MUL_W     = 18;              // serial multiplier operand width
    localparam int PROD_W    = 2 * MUL_W + 1;
    localparam int ACC_W     = 25;              // pre-saturation result width
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 2;
    localparam int CFG_W     = 16;

    localparam logic [IDX_W-1:0] IDX_MODE       = 2'd0;
    localparam logic [IDX_W-1:0] IDX_BLOCK_LEN  = 2'd1;
    localparam logic [IDX_W-1:0] IDX_BEGIN_GAIN = 2'd2;
    localparam logic [IDX_W-1:0] IDX_END_GAIN   = 2'd3;

    typedef enum logic [1:0] {
        MODE_GAIN,
        MODE_RAMP,
        MODE_FADE,
        MODE_MIX
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // clamp a signed value to the Q1.15 range
    function automatic logic [SAMPLE_W-1:0] sat16(input logic [ACC_W-1:0] y);
        logic [SAMPLE_W-1:0] r;
        begin
            if (!y[ACC_W-1] && (|y[ACC_W-2:SAMPLE_W-1]))
            begin
                r = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            else if (y[ACC_W-1] && !(&y[ACC_W-2:SAMPLE_W-1]))
            begin
                r = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            else
            begin
                r = y[SAMPLE_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/audio_gain_ramp_crossfade.sv =====
// Gain ramp, crossfade and mix for Q1.15 audio, with a bit-serial divider
// and a shift-add multiplier. Depends on agrc_pkg.
//
// One item (sample A, sample B) is processed at a time. The fade weight
// position/(length-1) comes from a restoring divider, one quotient bit a cycle,
// and products from a shift-add multiplier, one multiplier bit a cycle. Mix
// mode uses neither; constant gain takes one product, crossfade a division and
// one product, and gain ramp a division and two products. With a block length
// of one the divider is skipped. A finished sample sits in an output register,
// so the next item is taken while it waits; the following result then holds
// the input off until that register drains. Configuration writes never reset
// the block position.
module audio_gain_ramp_crossfade (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [2*agrc_pkg::SAMPLE_W-1:0]      s_tdata,   // sample_a, sample_b
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [agrc_pkg::SAMPLE_W-1:0]        m_tdata,   // sample_out
    output logic                                 m_tlast,   // block_end
    input  logic                                 cfg_we,
    input  logic [agrc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [agrc_pkg::CFG_W-1:0]           cfg_data
);
    import agrc_pkg::*;

    state_t              state_reg, state_next;
    mode_t               mode_reg;
    logic [LEN_W-1:0]    block_len_reg;
    logic [GAIN_W-1:0]   begin_gain_reg;
    logic [GAIN_W-1:0]   end_gain_reg;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SAMPLE_W-1:0] a_reg, a_next;
    logic                last_reg, last_next;
    logic                pass_reg, pass_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [POS_W:0]      rem_reg, rem_next;
    logic [WT_W-1:0]     q_reg, q_next;
    logic [MUL_W-1:0]    m_reg, m_next;
    logic [MUL_W-1:0]    n_reg, n_next;
    logic [MUL_W:0]      hi_reg, hi_next;
    logic [MUL_W-1:0]    lo_reg, lo_next;
    logic [SAMPLE_W-1:0] y_reg, y_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic [LEN_W-1:0]    len_eff;
    logic [POS_W-1:0]    div_d;
    logic [POS_W-1:0]    p_cur;
    logic                last_cur;
    logic [SAMPLE_W-1:0] in_a, in_b;
    logic                div_ge;
    logic [POS_W:0]      rem_sub;
    logic [MUL_W:0]      m_ext, addend, mul_sum;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-17:0]  prod_hi16;
    logic [MUL_W-1:0]    ramp_gain;
    logic [ACC_W-1:0]    fade_y;

    assign in_a = s_tdata[SAMPLE_W-1:0];
    assign in_b = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

    always_comb
    begin
        if (block_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (block_len_reg > LEN_W'(MAX_BLOCK))
        begin
            len_eff = LEN_W'(MAX_BLOCK);
        end
        else
        begin
            len_eff = block_len_reg;
        end
    end

    assign div_d    = POS_W'(len_eff - LEN_W'(1));
    assign p_cur    = (pos_reg > div_d) ? div_d : pos_reg;
    assign last_cur = (p_cur == div_d);

    // divider step
    assign div_ge  = (rem_reg >= {1'b0, div_d});
    assign rem_sub = div_ge ? (rem_reg - {1'b0, div_d}) : rem_reg;

    // multiplier step, last bit of the multiplier carries negative weight
    assign m_ext   = {m_reg[MUL_W-1], m_reg};
    assign addend  = n_reg[0] ? ((cnt_reg == CNT_W'(MUL_W-1)) ? (~m_ext + 1'b1) : m_ext)
                              : '0;
    assign mul_sum = hi_reg + addend;
    assign prod    = {mul_sum[MUL_W], mul_sum, lo_reg[MUL_W-1:1]};
    assign prod_hi16 = prod[PROD_W-1:16];
    assign ramp_gain = {{(MUL_W-GAIN_W){begin_gain_reg[GAIN_W-1]}}, begin_gain_reg}
                       + prod_hi16[MUL_W-1:0];
    assign fade_y    = {{(ACC_W-SAMPLE_W){a_reg[SAMPLE_W-1]}}, a_reg}
                       + {{(ACC_W-(PROD_W-16)){prod_hi16[PROD_W-17]}}, prod_hi16};

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        a_next         = a_reg;
        last_next      = last_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    a_next    = in_a;
                    last_next = last_cur;
                    pos_next  = last_cur ? '0 : p_cur + POS_W'(1);
                    pass_next = 1'b0;
                    cnt_next  = '0;
                    hi_next   = '0;
                    lo_next   = '0;
                    rem_next  = {1'b0, p_cur};
                    q_next    = '0;
                    n_next    = '0;
                    case (mode_reg)
                        MODE_GAIN:
                        begin
                            m_next     = {{(MUL_W-GAIN_W){begin_gain_reg[GAIN_W-1]}},
                                          begin_gain_reg};
                            n_next     = {{(MUL_W-SAMPLE_W){in_a[SAMPLE_W-1]}}, in_a};
                            state_next = ST_MUL;
                        end
                        MODE_RAMP:
                        begin
                            m_next     = {end_gain_reg[GAIN_W-1], end_gain_reg[GAIN_W-1],
                                          end_gain_reg}
                                         - {begin_gain_reg[GAIN_W-1],
                                            begin_gain_reg[GAIN_W-1], begin_gain_reg};
                            state_next = (div_d == '0) ? ST_MUL : ST_DIV;
                        end
                        MODE_FADE:
                        begin
                            m_next     = {in_b[SAMPLE_W-1], in_b[SAMPLE_W-1], in_b}
                                         - {in_a[SAMPLE_W-1], in_a[SAMPLE_W-1], in_a};
                            state_next = (div_d == '0) ? ST_MUL : ST_DIV;
                        end
                        default:
                        begin
                            y_next     = sat16({{(ACC_W-SAMPLE_W){in_a[SAMPLE_W-1]}}, in_a}
                                               + {{(ACC_W-SAMPLE_W){in_b[SAMPLE_W-1]}}, in_b});
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = {rem_sub[POS_W-1:0], 1'b0};
                q_next   = {q_reg[WT_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WT_W-1))
                begin
                    n_next     = {{(MUL_W-WT_W){1'b0}}, q_reg[WT_W-2:0], div_ge};
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                hi_next  = {mul_sum[MUL_W], mul_sum[MUL_W:1]};
                lo_next  = {mul_sum[0], lo_reg[MUL_W-1:1]};
                n_next   = {1'b0, n_reg[MUL_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_W-1))
                begin
                    cnt_next = '0;
                    if (mode_reg == MODE_RAMP && !pass_reg)
                    begin
                        // second pass: sample A times the interpolated gain
                        m_next    = ramp_gain;
                        n_next    = {{(MUL_W-SAMPLE_W){a_reg[SAMPLE_W-1]}}, a_reg};
                        hi_next   = '0;
                        lo_next   = '0;
                        pass_next = 1'b1;
                    end
                    else if (mode_reg == MODE_FADE)
                    begin
                        y_next     = sat16(fade_y);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        y_next     = sat16(prod[ACC_W+11:12]);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = y_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            pass_reg       <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_GAIN;
            block_len_reg  <= LEN_W'(4096);
            begin_gain_reg <= GAIN_W'(4096);
            end_gain_reg   <= GAIN_W'(4096);
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    IDX_MODE:       mode_reg       <= mode_t'(cfg_data[1:0]);
                    IDX_BLOCK_LEN:  block_len_reg  <= cfg_data[LEN_W-1:0];
                    IDX_BEGIN_GAIN: begin_gain_reg <= cfg_data[GAIN_W-1:0];
                    IDX_END_GAIN:   end_gain_reg   <= cfg_data[GAIN_W-1:0];
                    default:        mode_reg       <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/agrc_checker.sv =====
// Port-level checks for audio_gain_ramp_crossfade, attached by bind.
// Depends on the top level's port list only.
module agrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // one item in flight: no input taken in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a result never appears straight after its item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result too early");

endmodule

bind audio_gain_ramp_crossfade agrc_checker u_agrc_checker (.*);
